FILE: rtl/anaglyph_pixel_encoder_with_ycbcr_macros.svh
// ----------------------------------------------------------------------------
// Anaglyph pixel encoder assertion macros
// Shared property forms for the checker; clock and reset come from the scope.
// ----------------------------------------------------------------------------
`ifndef ANAGLYPH_PIXEL_ENCODER_WITH_YCBCR_MACROS_SVH
`define ANAGLYPH_PIXEL_ENCODER_WITH_YCBCR_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define APEY_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define APEY_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/apey_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph pixel encoder package
// Transaction types, default coefficient precision and coefficient helper.
// ----------------------------------------------------------------------------
package apey_pkg;

   localparam int unsigned COEF_FRAC_BITS_DEF = 16;

   // BT.601 coefficients in thousandths
   localparam int unsigned MILLI_KR = 299;
   localparam int unsigned MILLI_KG = 587;
   localparam int unsigned MILLI_KB = 114;
   localparam int unsigned MILLI_KU = 564;
   localparam int unsigned MILLI_KV = 713;

   typedef struct packed {
      logic [7:0] left_blue;
      logic [7:0] left_green;
      logic [7:0] left_red;
      logic [7:0] right_blue;
      logic [7:0] right_green;
      logic [7:0] right_red;
   } req_type;

   typedef struct packed {
      logic [7:0] anaglyph_blue;
      logic [7:0] anaglyph_green;
      logic [7:0] anaglyph_red;
      logic [7:0] spare_left_green;
      logic [7:0] spare_right_red;
      logic [7:0] spare_right_blue;
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } rsp_type;

   // round(milli / 1000 * 2^frac), evaluated at elaboration
   function automatic logic [31:0] fix_coef(input int unsigned milli,
                                            input int unsigned frac);
      logic [63:0] scaled;
      scaled = (64'(milli) << frac) + 64'd500;
      return 32'(scaled / 64'd1000);
   endfunction

endpackage

FILE: rtl/apey_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph luma stages
// Stage 1 forms the three weighted channel products, stage 2 sums them into
// the unrounded luma and the blue and red differences.
// ----------------------------------------------------------------------------
module apey_luma #(
   parameter int unsigned COEF_FRAC_BITS = apey_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  apey_pkg::req_type               req_data,
   output logic                            out_valid,
   input  logic                            out_stall,
   output apey_pkg::req_type               out_pix,
   output logic [COEF_FRAC_BITS+9:0]       out_yf,
   output logic signed [COEF_FRAC_BITS+10:0] out_bdiff,
   output logic signed [COEF_FRAC_BITS+10:0] out_rdiff
);
   import apey_pkg::*;

   localparam int unsigned F   = COEF_FRAC_BITS;
   localparam int unsigned P_W = F + 8;
   localparam int unsigned Y_W = F + 10;
   localparam int unsigned D_W = F + 11;

   localparam logic [F-1:0] KR = F'(fix_coef(MILLI_KR, F));
   localparam logic [F-1:0] KG = F'(fix_coef(MILLI_KG, F));
   localparam logic [F-1:0] KB = F'(fix_coef(MILLI_KB, F));

   logic             v1_ff, v1_in, adv1;
   logic             v2_ff, v2_in, adv2;
   req_type          pix1_ff, pix2_ff;
   logic [P_W-1:0]   pr_ff, pr_in, pg_ff, pg_in, pb_ff, pb_in;
   logic [Y_W-1:0]   yf_ff, yf_in;
   logic signed [D_W-1:0] bd_ff, bd_in, rd_ff, rd_in;

   assign adv2 = !v2_ff || !out_stall;
   assign adv1 = !v1_ff || !(v2_ff && out_stall);
   assign req_stall = !adv1;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;

   // stage 1: anaglyph takes left blue, right green, left red
   assign pr_in = P_W'(KR) * P_W'(req_data.left_red);
   assign pg_in = P_W'(KG) * P_W'(req_data.right_green);
   assign pb_in = P_W'(KB) * P_W'(req_data.left_blue);

   // stage 2
   assign yf_in = Y_W'(pr_ff) + Y_W'(pg_ff) + Y_W'(pb_ff);
   assign bd_in = $signed({3'b000, pix1_ff.left_blue, {F{1'b0}}}) - $signed({1'b0, yf_in});
   assign rd_in = $signed({3'b000, pix1_ff.left_red, {F{1'b0}}}) - $signed({1'b0, yf_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         pix1_ff <= req_data;
         pr_ff   <= pr_in;
         pg_ff   <= pg_in;
         pb_ff   <= pb_in;
      end
      if (adv2) begin
         pix2_ff <= pix1_ff;
         yf_ff   <= yf_in;
         bd_ff   <= bd_in;
         rd_ff   <= rd_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_pix   = pix2_ff;
   assign out_yf    = yf_ff;
   assign out_bdiff = bd_ff;
   assign out_rdiff = rd_ff;

endmodule

FILE: rtl/apey_chroma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph chroma product stage
// Stage 3 scales the blue and red differences and rounds the luma.
// ----------------------------------------------------------------------------
module apey_chroma #(
   parameter int unsigned COEF_FRAC_BITS = apey_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  apey_pkg::req_type                   in_pix,
   input  logic [COEF_FRAC_BITS+9:0]           in_yf,
   input  logic signed [COEF_FRAC_BITS+10:0]   in_bdiff,
   input  logic signed [COEF_FRAC_BITS+10:0]   in_rdiff,
   output logic                                out_valid,
   input  logic                                out_stall,
   output apey_pkg::req_type                   out_pix,
   output logic [7:0]                          out_luma,
   output logic signed [2*COEF_FRAC_BITS+11:0] out_pu,
   output logic signed [2*COEF_FRAC_BITS+11:0] out_pv
);
   import apey_pkg::*;

   localparam int unsigned F   = COEF_FRAC_BITS;
   localparam int unsigned Y_W = F + 10;
   localparam int unsigned M_W = 2 * F + 12;

   localparam logic [F-1:0] KU = F'(fix_coef(MILLI_KU, F));
   localparam logic [F-1:0] KV = F'(fix_coef(MILLI_KV, F));
   localparam logic [Y_W:0] Y_RND = (Y_W + 1)'((64'd1 << (F - 1)) - 64'd1);

   logic                  v3_ff, v3_in, adv3;
   req_type               pix3_ff;
   logic [7:0]            luma_ff, luma_in;
   logic [Y_W:0]          yt;
   logic signed [M_W-1:0] pu_ff, pu_in, pv_ff, pv_in;

   assign adv3     = !v3_ff || !out_stall;
   assign in_stall = !adv3;
   assign v3_in    = adv3 ? in_valid : v3_ff;

   assign pu_in = M_W'($signed({1'b0, KU})) * M_W'(in_bdiff);
   assign pv_in = M_W'($signed({1'b0, KV})) * M_W'(in_rdiff);

   // round to nearest, ties down; luma is never negative
   assign yt = {1'b0, in_yf} + Y_RND;
   always_comb begin
      if (|yt[Y_W:F+8]) begin
         luma_in = 8'hFF;
      end else begin
         luma_in = yt[F+7:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         pix3_ff <= in_pix;
         luma_ff <= luma_in;
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_pix   = pix3_ff;
   assign out_luma  = luma_ff;
   assign out_pu    = pu_ff;
   assign out_pv    = pv_ff;

endmodule

FILE: rtl/apey_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph output stage
// Stage 4 adds the chroma offset, rounds, saturates and holds the result.
// ----------------------------------------------------------------------------
module apey_out #(
   parameter int unsigned COEF_FRAC_BITS = apey_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  apey_pkg::req_type                   in_pix,
   input  logic [7:0]                          in_luma,
   input  logic signed [2*COEF_FRAC_BITS+11:0] in_pu,
   input  logic signed [2*COEF_FRAC_BITS+11:0] in_pv,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output apey_pkg::rsp_type                   rsp_data
);
   import apey_pkg::*;

   localparam int unsigned F   = COEF_FRAC_BITS;
   localparam int unsigned S   = 2 * F;
   localparam int unsigned M_W = 2 * F + 12;

   // offset of 128 plus the round-half-down bias, both at 2F fraction bits
   localparam logic signed [M_W-1:0] C_RND =
      (M_W'(128) <<< S) + (M_W'(1) <<< (S - 1)) - M_W'(1);

   logic                  v4_ff, v4_in, adv4;
   rsp_type               rsp_ff, rsp_in;
   logic signed [M_W-1:0] ut, vt;
   logic [7:0]            u_sat, v_sat;

   assign adv4     = !v4_ff || !rsp_stall;
   assign in_stall = !adv4;
   assign v4_in    = adv4 ? in_valid : v4_ff;

   assign ut = in_pu + C_RND;
   assign vt = in_pv + C_RND;

   always_comb begin
      priority if (ut[M_W-1]) begin
         u_sat = 8'h00;
      end else if (|ut[M_W-2:S+8]) begin
         u_sat = 8'hFF;
      end else begin
         u_sat = ut[S+7:S];
      end
      priority if (vt[M_W-1]) begin
         v_sat = 8'h00;
      end else if (|vt[M_W-2:S+8]) begin
         v_sat = 8'hFF;
      end else begin
         v_sat = vt[S+7:S];
      end
   end

   always_comb begin
      rsp_in.anaglyph_blue    = in_pix.left_blue;
      rsp_in.anaglyph_green   = in_pix.right_green;
      rsp_in.anaglyph_red     = in_pix.left_red;
      rsp_in.spare_left_green = in_pix.left_green;
      rsp_in.spare_right_red  = in_pix.right_red;
      rsp_in.spare_right_blue = in_pix.right_blue;
      rsp_in.luma             = in_luma;
      rsp_in.chroma_u         = u_sat;
      rsp_in.chroma_v         = v_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
      end
   end

   // hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (adv4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/anaglyph_pixel_encoder_with_ycbcr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph pixel encoder with YCbCr
// Green/magenta anaglyph from a stereo BGR pair, with BT.601 luma and chroma.
// ----------------------------------------------------------------------------
// Channel  Ports                          Direction  Payload
// req      req_valid req_stall req_data   in         left and right BGR pixel
// rsp      rsp_valid rsp_stall rsp_data   out        anaglyph, spares, Y U V
//
// One pixel per clock sustained while rsp_stall is low; a pixel passes
// through the four register stages (luma products, luma sum and
// differences, chroma products, offset/round/saturate) to rsp_valid.
// Synchronous active-high reset clears only the stage valid bits.
// A rsp stall backs up stage by stage; empty stages still fill, so req_stall
// rises only when all four stages hold a transaction.
// ----------------------------------------------------------------------------
module anaglyph_pixel_encoder_with_ycbcr #(
   parameter int unsigned COEF_FRAC_BITS = apey_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  apey_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apey_pkg::rsp_type rsp_data
);
   import apey_pkg::*;

   localparam int unsigned F = COEF_FRAC_BITS;

   logic                      s2_valid, s2_stall;
   req_type                   s2_pix;
   logic [F+9:0]              s2_yf;
   logic signed [F+10:0]      s2_bdiff, s2_rdiff;
   logic                      s3_valid, s3_stall;
   req_type                   s3_pix;
   logic [7:0]                s3_luma;
   logic signed [2*F+11:0]    s3_pu, s3_pv;

   apey_luma #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_luma (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_pix   (s2_pix),
      .out_yf    (s2_yf),
      .out_bdiff (s2_bdiff),
      .out_rdiff (s2_rdiff)
   );

   apey_chroma #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_pix    (s2_pix),
      .in_yf     (s2_yf),
      .in_bdiff  (s2_bdiff),
      .in_rdiff  (s2_rdiff),
      .out_valid (s3_valid),
      .out_stall (s3_stall),
      .out_pix   (s3_pix),
      .out_luma  (s3_luma),
      .out_pu    (s3_pu),
      .out_pv    (s3_pv)
   );

   apey_out #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_stall  (s3_stall),
      .in_pix    (s3_pix),
      .in_luma   (s3_luma),
      .in_pu     (s3_pu),
      .in_pv     (s3_pv),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/apey_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anaglyph pixel encoder checker
// Port-level properties of the four-stage encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "anaglyph_pixel_encoder_with_ycbcr_macros.svh"

module apey_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input apey_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input apey_pkg::rsp_type rsp_data
);
   import apey_pkg::*;

   // pipeline is empty right after reset
   `APEY_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result valid right after reset")

   // a stalled result holds
   `APEY_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // input backs up only when the output is full and stalled
   `APEY_ASSERT_NOW(a_stall_full, req_stall, rsp_valid && rsp_stall, "input stalled with room in the pipeline")

   // with no output stall, an accepted transaction comes out with its channels routed
   `APEY_ASSERT_NEXT(a_route, req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall, rsp_valid && rsp_data.anaglyph_blue == $past(req_data.left_blue, 4) && rsp_data.anaglyph_green == $past(req_data.right_green, 4) && rsp_data.spare_right_blue == $past(req_data.right_blue, 4), "pixel not routed with four-cycle latency")

endmodule

bind anaglyph_pixel_encoder_with_ycbcr apey_checker u_apey_checker (.*);
